>>> sv/mchs_pkg.sv
`timescale 1ns / 1ps

package mchs_pkg;

  // Field widths fixed by the request and result formats
  localparam int CH_BITS    = 4;
  localparam int CFG_BITS   = 5;
  localparam int VAL_BITS   = 32;
  localparam int TOTAL_BITS = 40;

  localparam logic [CFG_BITS-1:0] ACTIVE_RESET = 5'd4;

  typedef enum logic [1:0] {
    REQ_OBSERVE = 2'd0,
    REQ_WRITE   = 2'd1,
    REQ_HOP1    = 2'd2,
    REQ_HOP2    = 2'd3
  } req_e;

  // Multiply-accumulate unit controls
  typedef struct packed {
    logic clr;
    logic mul;
    logic add;
    logic hi;
  } mac_ctl_t;

endpackage

>>> sv/mchs_if.sv
`timescale 1ns / 1ps

interface mchs_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [mchs_pkg::CH_BITS-1:0]  from_channel;
  logic [mchs_pkg::CH_BITS-1:0]  to_channel;
  logic                          forbid_enable;
  logic [mchs_pkg::VAL_BITS-1:0] count_value;

  modport source (output valid, req_type, from_channel, to_channel, forbid_enable,
                  count_value, input ready);
  modport sink (input valid, req_type, from_channel, to_channel, forbid_enable,
                count_value, output ready);
endinterface

interface mchs_res_if;
  logic                         valid;
  logic                         ready;
  logic [mchs_pkg::CH_BITS-1:0] channel;
  logic                         found;

  modport source (output valid, channel, found, input ready);
  modport sink (input valid, channel, found, output ready);
endinterface

>>> sv/markov_channel_hop_selector.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake      Payload
// req       in   valid/ready    req_type, from_channel, to_channel, forbid_enable, count_value
// res       out  valid/ready    channel, found
// cfg       in   cfg_we         cfg_data (active_channels)
//
// Observe and write read the entry, then update it and the total; with a channel out of
// range they are dropped. Query time is set by the single table read port and the one
// shared 32x32 multiplier, and grows with the number of active channels; a forbidden
// candidate is skipped. A query with no data or a bad channel ends early. After reset a
// clearing pass writes zero to all MAX_CHANNELS^2 entries before req goes ready.
// One item at a time; a held result stalls only the end of the next query.

module markov_channel_hop_selector #(
  parameter int MAX_CHANNELS = 16,
  parameter int COUNT_BITS   = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mchs_pkg::CFG_BITS-1:0] cfg_data,
  mchs_req_if.sink                      req,
  mchs_res_if.source                    res
);
  import mchs_pkg::*;

  localparam int DEPTH = MAX_CHANNELS * MAX_CHANNELS;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int NW    = $clog2(MAX_CHANNELS + 1);
  localparam int ACC_W = TOTAL_BITS + COUNT_BITS + 8;
  localparam logic [COUNT_BITS-1:0] ENTRY_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISP, S_ENT_RD, S_UPD, S_ROW_RD, S_ROW_CHK,
    S_CAND, S_RA, S_RB, S_MUL, S_ACC, S_RS, S_RC, S_M1, S_A1, S_M2, S_A2,
    S_CMP, S_DONE
  } state_t;

  state_t                  st;
  logic [IDX_W-1:0]        clr_idx;
  logic [CFG_BITS-1:0]     active;
  logic [TOTAL_BITS-1:0]   total;
  req_e                    r_type;
  logic [CH_BITS-1:0]      r_from;
  logic [CH_BITS-1:0]      r_to;
  logic                    r_forbid;
  logic [COUNT_BITS-1:0]   r_value;
  logic [NW-1:0]           m;
  logic [NW-1:0]           i;
  logic [NW-1:0]           best;
  logic                    nz;
  logic                    have;
  logic [COUNT_BITS-1:0]   low1;
  logic [ACC_W-1:0]        low2;
  logic [COUNT_BITS-1:0]   opa;
  logic [TOTAL_BITS-1:0]   d;
  logic                    res_valid;
  logic [CH_BITS-1:0]      res_channel;
  logic                    res_found;

  logic [NW-1:0]           n;
  logic                    from_ok;
  logic                    to_ok;
  logic                    last_m;
  logic                    last_i;
  logic                    nz_next;
  logic                    we;
  logic [IDX_W-1:0]        waddr;
  logic [COUNT_BITS-1:0]   wdata;
  logic [IDX_W-1:0]        raddr;
  logic [COUNT_BITS-1:0]   rdata;
  logic [TOTAL_BITS:0]     wr_sum;
  logic [TOTAL_BITS-1:0]   wr_total;
  mac_ctl_t                mac_ctl;
  logic [VAL_BITS-1:0]     mac_a;
  logic [COUNT_BITS-1:0]   mac_b;
  logic [ACC_W-1:0]        acc;

  function automatic logic [IDX_W-1:0] idx(input int r, input int c);
    return IDX_W'(r * MAX_CHANNELS + c);
  endfunction

  mchs_table #(.DEPTH(DEPTH), .AW(IDX_W), .DW(COUNT_BITS)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  mchs_mac #(.COUNT_BITS(COUNT_BITS), .ACC_W(ACC_W)) u_mac (
    .clk(clk), .ctl(mac_ctl), .a(mac_a), .b(mac_b), .acc(acc)
  );

  // Clamp channel count and check ranges
  always_comb begin
    if (int'(active) > MAX_CHANNELS) begin
      n = NW'(MAX_CHANNELS);
    end else begin
      n = NW'(active);
    end
    from_ok = int'(r_from) < int'(n);
    to_ok   = int'(r_to) < int'(n);
    last_m  = (m == n - 1'b1);
    last_i  = (i == n - 1'b1);
    nz_next = nz | (rdata != '0);
  end

  // Table read address
  always_comb begin
    case (st)
      S_ENT_RD: raddr = idx(int'(r_from), int'(r_to));
      S_ROW_RD: raddr = idx(int'(r_from), int'(m));
      S_RA:     raddr = idx(int'(r_from), int'(m));
      S_RB:     raddr = idx(int'(m), int'(i));
      S_RS:     raddr = idx(int'(i), int'(i));
      S_RC:     raddr = idx(int'(r_from), int'(i));
      default:  raddr = '0;
    endcase
  end

  // Table write and new total
  always_comb begin
    wr_sum = (total >= TOTAL_BITS'(rdata)) ? {1'b0, total - TOTAL_BITS'(rdata)} : '0;
    wr_sum = wr_sum + (TOTAL_BITS + 1)'(r_value);
    wr_total = wr_sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : wr_sum[TOTAL_BITS-1:0];
    we    = 1'b0;
    waddr = idx(int'(r_from), int'(r_to));
    wdata = r_value;
    if (st == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_idx;
      wdata = '0;
    end else if (st == S_UPD) begin
      if (r_type == REQ_OBSERVE) begin
        we    = (rdata != ENTRY_MAX);
        wdata = rdata + 1'b1;
      end else begin
        we = 1'b1;
      end
    end
  end

  // Drive the shared multiply-accumulate unit
  always_comb begin
    mac_ctl = '0;
    mac_a   = VAL_BITS'(opa);
    mac_b   = rdata;
    case (st)
      S_CAND: mac_ctl.clr = 1'b1;
      S_MUL:  mac_ctl.mul = 1'b1;
      S_M1: begin
        mac_ctl.mul = 1'b1;
        mac_a       = d[VAL_BITS-1:0];
      end
      S_M2: begin
        mac_ctl.mul = 1'b1;
        mac_a       = VAL_BITS'(d[TOTAL_BITS-1:VAL_BITS]);
        mac_b       = opa;
      end
      S_ACC, S_A1: mac_ctl.add = 1'b1;
      S_A2: begin
        mac_ctl.add = 1'b1;
        mac_ctl.hi  = 1'b1;
      end
      default: ;
    endcase
  end

  assign req.ready   = (st == S_IDLE);
  assign res.valid   = res_valid;
  assign res.channel = res_channel;
  assign res.found   = res_found;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_CLEAR;
      clr_idx   <= '0;
      active    <= ACTIVE_RESET;
      total     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        active <= cfg_data;
      end
      // Drop the result after its transfer unless a new one is loaded
      if (res_valid && res.ready && st != S_DONE) begin
        res_valid <= 1'b0;
      end
      unique case (st)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (int'(clr_idx) == DEPTH - 1) begin
            st <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            r_type   <= req_e'(req.req_type);
            r_from   <= req.from_channel;
            r_to     <= req.to_channel;
            r_forbid <= req.forbid_enable;
            r_value  <= req.count_value[COUNT_BITS-1:0];
            st       <= S_DISP;
          end
        end
        S_DISP: begin
          m    <= '0;
          i    <= '0;
          have <= 1'b0;
          nz   <= 1'b0;
          if (r_type == REQ_OBSERVE || r_type == REQ_WRITE) begin
            st <= (from_ok && to_ok) ? S_ENT_RD : S_IDLE;
          end else if (!from_ok || total == '0) begin
            st <= S_DONE;
          end else begin
            st <= S_ROW_RD;
          end
        end
        S_ENT_RD: st <= S_UPD;
        S_UPD: begin
          if (r_type == REQ_OBSERVE) begin
            if (rdata != ENTRY_MAX && total != {TOTAL_BITS{1'b1}}) begin
              total <= total + 1'b1;
            end
          end else begin
            total <= wr_total;
          end
          st <= S_IDLE;
        end
        S_ROW_RD: st <= S_ROW_CHK;
        S_ROW_CHK: begin
          nz <= nz_next;
          if (r_type == REQ_HOP1 && int'(m) != int'(r_from) && (!have || rdata < low1)) begin
            have <= 1'b1;
            low1 <= rdata;
            best <= m;
          end
          if (!last_m) begin
            m  <= m + 1'b1;
            st <= S_ROW_RD;
          end else if (r_type == REQ_HOP1 || !nz_next) begin
            st <= S_DONE;
          end else begin
            st <= S_CAND;
          end
        end
        S_CAND: begin
          m <= '0;
          if (r_forbid && int'(i) == int'(r_to)) begin
            if (last_i) begin
              st <= S_DONE;
            end else begin
              i <= i + 1'b1;
            end
          end else begin
            st <= S_RA;
          end
        end
        S_RA: st <= S_RB;
        S_RB: begin
          opa <= rdata;
          st  <= S_MUL;
        end
        S_MUL: st <= S_ACC;
        S_ACC: begin
          if (last_m) begin
            st <= S_RS;
          end else begin
            m  <= m + 1'b1;
            st <= S_RA;
          end
        end
        S_RS: st <= S_RC;
        S_RC: begin
          d  <= (total >= TOTAL_BITS'(rdata)) ? total - TOTAL_BITS'(rdata) : '0;
          st <= S_M1;
        end
        S_M1: begin
          opa <= rdata;
          st  <= S_A1;
        end
        S_A1: st <= S_M2;
        S_M2: st <= S_A2;
        S_A2: st <= S_CMP;
        S_CMP: begin
          if (!have || acc < low2) begin
            have <= 1'b1;
            low2 <= acc;
            best <= i;
          end
          if (last_i) begin
            st <= S_DONE;
          end else begin
            i  <= i + 1'b1;
            st <= S_CAND;
          end
        end
        S_DONE: begin
          // Hold until the output register is free
          if (!res_valid || res.ready) begin
            res_valid   <= 1'b1;
            res_found   <= have && nz;
            res_channel <= (have && nz) ? CH_BITS'(best) : '0;
            st          <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/mchs_table.sv
`timescale 1ns / 1ps

module mchs_table #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/mchs_mac.sv
`timescale 1ns / 1ps

module mchs_mac #(
  parameter int COUNT_BITS = 32,
  parameter int ACC_W      = 80
) (
  input  logic                          clk,
  input  mchs_pkg::mac_ctl_t            ctl,
  input  logic [mchs_pkg::VAL_BITS-1:0] a,
  input  logic [COUNT_BITS-1:0]         b,
  output logic [ACC_W-1:0]              acc
);
  import mchs_pkg::*;

  localparam int PW = VAL_BITS + COUNT_BITS;

  logic [PW-1:0] prod;

  // Register the product, then fold it into the accumulator
  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= a * b;
    end
    if (ctl.clr) begin
      acc <= '0;
    end else if (ctl.add) begin
      if (ctl.hi) begin
        acc <= acc + (ACC_W'(prod) << VAL_BITS);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

endmodule

>>> tb/tb_markov_channel_hop_selector.sv
`timescale 1ns / 1ps

module tb_markov_channel_hop_selector;
  import mchs_pkg::*;

  localparam int NCH       = 16;
  localparam longint CMAX  = 64'hFFFF_FFFF;
  localparam longint TMAX  = 64'hFF_FFFF_FFFF;
  localparam int CYC_LIMIT = 10_000_000;

  typedef struct {
    req_e                  kind;
    logic [CH_BITS-1:0]    from_ch;
    logic [CH_BITS-1:0]    to_ch;
    logic                  forbid;
    logic [VAL_BITS-1:0]   value;
  } hop_req_t;

  typedef struct {
    logic [CH_BITS-1:0] channel;
    logic               found;
  } hop_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  mchs_req_if req ();
  mchs_res_if res ();

  markov_channel_hop_selector u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req.sink),
    .res      (res.source)
  );

  always #5 clk = ~clk;

  // Shadow copy of the table, total and channel count
  longint unsigned counts[NCH*NCH];
  longint unsigned total;
  int unsigned     n_active;

  hop_req_t pending_reqs[$];
  hop_res_t expected_picks[$];
  int errors = 0;
  int cycles = 0;
  bit hold_off = 0;

  function automatic int rand_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Apply one request to the shadow state; return 1 with the pick for queries
  function automatic bit predict_hop(hop_req_t r, output hop_res_t pick);
    int unsigned n, idx, c;
    bit row_zero, have;
    longint unsigned low1, d, self_cnt, t;
    logic [127:0] s, low2;
    n = n_active > NCH ? NCH : n_active;
    c = r.from_ch;
    pick.channel = '0;
    pick.found = 1'b0;
    if (r.kind == REQ_OBSERVE || r.kind == REQ_WRITE) begin
      if (r.from_ch >= n || r.to_ch >= n) return 0;
      idx = r.from_ch * NCH + r.to_ch;
      if (r.kind == REQ_OBSERVE) begin
        if (counts[idx] < CMAX) begin
          counts[idx]++;
          if (total < TMAX) total++;
        end
      end else begin
        t = total >= counts[idx] ? total - counts[idx] : 0;
        t += r.value;
        total = t > TMAX ? TMAX : t;
        counts[idx] = r.value;
      end
      return 0;
    end
    if (c >= n || total == 0) return 1;
    row_zero = 1;
    for (int i = 0; i < n; i++) if (counts[c*NCH+i] != 0) row_zero = 0;
    if (row_zero) return 1;
    have = 0;
    low1 = 0;
    low2 = '0;
    for (int i = 0; i < n; i++) begin
      if (r.kind == REQ_HOP1) begin
        if (i == c) continue;
        if (!have || counts[c*NCH+i] < low1) begin
          have = 1; low1 = counts[c*NCH+i]; pick.channel = CH_BITS'(i);
        end
      end else begin
        if (r.forbid && i == r.to_ch) continue;
        self_cnt = counts[i*NCH+i];
        d = total >= self_cnt ? total - self_cnt : 0;
        s = '0;
        for (int m = 0; m < n; m++)
          s += 128'(counts[c*NCH+m]) * 128'(counts[m*NCH+i]);
        s += 128'(d) * 128'(counts[c*NCH+i]);
        if (!have || s < low2) begin
          have = 1; low2 = s; pick.channel = CH_BITS'(i);
        end
      end
    end
    pick.found = have;
    return 1;
  endfunction

  function automatic hop_req_t mk(req_e k, int f, int t, bit fb, logic [31:0] v);
    hop_req_t r;
    r.kind = k; r.from_ch = CH_BITS'(f); r.to_ch = CH_BITS'(t); r.forbid = fb; r.value = v;
    return r;
  endfunction

  // Random request, mostly within the active range
  function automatic hop_req_t rand_req(int n);
    hop_req_t r;
    int sel;
    int hi;
    sel = $urandom_range(0, 99);
    hi = ($urandom_range(0, 9) == 0) ? 15 : n - 1;
    r.from_ch = CH_BITS'($urandom_range(0, hi));
    r.to_ch = CH_BITS'($urandom_range(0, hi));
    r.forbid = 1'($urandom_range(0, 1));
    r.value = $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 20);
    if ($urandom_range(0, 29) == 0) r.value = 32'hFFFF_FFFF;
    if (sel < 55) r.kind = REQ_OBSERVE;
    else if (sel < 70) r.kind = REQ_WRITE;
    else if (sel < 85) r.kind = REQ_HOP1;
    else r.kind = REQ_HOP2;
    return r;
  endfunction

  // Note a request transfer at the rising edge for the driver
  bit req_fire = 1'b0;
  always @(posedge clk) begin
    req_fire <= !rst && req.valid && req.ready;
  end

  // Drive requests from the pending queue, with random gaps
  int req_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (req.valid && !req_fire) begin
      // hold until transfer
    end else if (req_gap > 0) begin
      req_gap <= req_gap - 1;
      req.valid <= 1'b0;
    end else if (!hold_off && pending_reqs.size() > 0) begin
      hop_req_t r;
      r = pending_reqs.pop_front();
      req.valid <= 1'b1;
      req.req_type <= r.kind;
      req.from_channel <= r.from_ch;
      req.to_channel <= r.to_ch;
      req.forbid_enable <= r.forbid;
      req.count_value <= r.value;
      req_gap <= rand_gap();
    end else begin
      req.valid <= 1'b0;
    end
  end

  // Random backpressure on results
  int res_gap = 0;
  always @(negedge clk) begin
    if (res_gap > 0) begin
      res_gap <= res_gap - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
      res_gap <= rand_gap();
    end
  end

  // Predict on each request transfer, check each result transfer
  always @(posedge clk) begin
    hop_req_t r;
    hop_res_t p, e;
    cycles <= cycles + 1;
    if (!rst && req.valid && req.ready) begin
      r.kind = req_e'(req.req_type);
      r.from_ch = req.from_channel;
      r.to_ch = req.to_channel;
      r.forbid = req.forbid_enable;
      r.value = req.count_value;
      if (predict_hop(r, p)) expected_picks.push_back(p);
    end
    if (!rst && res.valid && res.ready) begin
      if (expected_picks.size() == 0) begin
        $error("unexpected result channel=%0d found=%0b", res.channel, res.found);
        errors++;
      end else begin
        e = expected_picks.pop_front();
        if (res.found !== e.found) begin
          $error("found: expected %0b, got %0b", e.found, res.found);
          errors++;
        end
        if (res.channel !== e.channel) begin
          $error("channel: expected %0d, got %0d", e.channel, res.channel);
          errors++;
        end
      end
    end
    if (cycles >= CYC_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req.valid || expected_picks.size() > 0)
      @(posedge clk);
    // observe and write give no result; let the last one finish
    repeat (20) @(posedge clk);
  endtask

  task automatic set_channels(int v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= CFG_BITS'(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    n_active = v;
  endtask

  initial begin
    int settings[6] = '{16, 2, 5, 31, 8, 3};
    int n;
    req.valid = 1'b0;
    req.req_type = '0;
    req.from_channel = '0;
    req.to_channel = '0;
    req.forbid_enable = 1'b0;
    req.count_value = '0;
    res.ready = 1'b0;
    foreach (counts[k]) counts[k] = 0;
    total = 0;
    n_active = ACTIVE_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero data, out of range, saturation, ties, forbid
    pending_reqs.push_back(mk(REQ_HOP1, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_HOP2, 1, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_OBSERVE, 0, 1, 0, 0));
    pending_reqs.push_back(mk(REQ_OBSERVE, 4, 1, 0, 0));
    pending_reqs.push_back(mk(REQ_WRITE, 1, 15, 0, 7));
    pending_reqs.push_back(mk(REQ_HOP1, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_HOP1, 5, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_HOP2, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_HOP2, 0, 0, 1, 0));
    pending_reqs.push_back(mk(REQ_HOP2, 2, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_WRITE, 3, 3, 0, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk(REQ_OBSERVE, 3, 3, 0, 0));
    pending_reqs.push_back(mk(REQ_WRITE, 2, 2, 0, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk(REQ_WRITE, 1, 1, 0, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk(REQ_WRITE, 0, 0, 0, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk(REQ_WRITE, 0, 2, 0, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk(REQ_HOP2, 0, 3, 1, 0));
    pending_reqs.push_back(mk(REQ_HOP2, 3, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_HOP1, 3, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_WRITE, 0, 2, 0, 0));
    pending_reqs.push_back(mk(REQ_HOP1, 15, 15, 1, 0));
    wait_drained();

    // Random phases across channel counts, extremes included
    foreach (settings[p]) begin
      set_channels(settings[p]);
      n = settings[p] > NCH ? NCH : settings[p];
      for (int k = 0; k < 200; k++) pending_reqs.push_back(rand_req(n));
      if (p == 2) begin
        // pause the sender until all results are in
        while (pending_reqs.size() > 100 || req.valid) @(posedge clk);
        hold_off = 1;
        while (expected_picks.size() > 0) @(posedge clk);
        hold_off = 0;
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
